/* sv/bss_pkg.sv */
// Package for the beta-spline segment evaluator: widths, constants and
// shared types. No dependencies.
package bss_pkg;

    localparam int POINT_BITS = 24;
    localparam int FRAC_BITS  = 16;
    localparam int IN_Q       = 16;
    localparam int U_W        = IN_Q + 1;
    localparam int T_W        = IN_Q + 1;
    localparam int OUT_BITS   = 40;

    localparam int L_W  = POINT_BITS + 6;
    localparam int PR_W = L_W + T_W;
    localparam int C_W  = PR_W + 1;

    localparam int N_CHUNK = 3;
    localparam int A_RAW   = C_W + 3 * U_W + 3;
    localparam int CH_W    = (A_RAW + N_CHUNK - 1) / N_CHUNK;
    localparam int A_W     = N_CHUNK * CH_W;
    localparam int PP_W    = CH_W + U_W;

    localparam int SH  = 4 * IN_Q - FRAC_BITS;
    localparam int S_W = A_W - SH;
    localparam int E_W = ((S_W > OUT_BITS + 4) ? S_W : OUT_BITS + 4) + 1;

    localparam int W_W   = OUT_BITS + 2;
    localparam int DIV_K = W_W + 2;
    localparam int M_W   = DIV_K - 1;
    localparam int W_LO  = W_W / 2;
    localparam int W_HI  = W_W - W_LO;
    localparam int M_LO  = M_W / 2;
    localparam int M_HI  = M_W - M_LO;
    localparam int PLL_W = W_LO + M_LO;
    localparam int PLH_W = W_LO + M_HI;
    localparam int PHL_W = W_HI + M_LO;
    localparam int PHH_W = W_HI + M_HI;
    localparam int P_W   = W_W + M_W;

    localparam int NSTG = 12;

    localparam logic [M_W-1:0] DIV3_M = M_W'(((64'd1 << DIV_K) + 64'd2) / 64'd3);
    localparam logic signed [E_W-1:0] OFF_V = E_W'(64'sd3 <<< OUT_BITS);
    localparam logic signed [E_W-1:0] LIM_V = E_W'(64'sd3 <<< (OUT_BITS + 1));
    localparam logic [T_W-1:0] TENSION_RST = T_W'(64'd1 << IN_Q);
    localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS - 1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS - 1){1'b0}}};

    typedef logic signed [C_W-1:0] bss_coef_t;

    typedef struct packed {
        logic lin;
        logic prod;
        logic coef;
    } bss_coef_ld_t;

    typedef struct packed {
        logic pp;
        logic sum;
    } bss_step_ld_t;

endpackage

/* sv/bss_if.sv */
// Stream interfaces of the beta-spline segment evaluator.
// Depends on bss_pkg for payload widths.
interface bss_in_if import bss_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic        [U_W-1:0]        param_u;
    logic signed [POINT_BITS-1:0] point_0;
    logic signed [POINT_BITS-1:0] point_1;
    logic signed [POINT_BITS-1:0] point_2;
    logic signed [POINT_BITS-1:0] point_3;

    modport source (output valid, output param_u, output point_0, output point_1,
                    output point_2, output point_3, input ready);
    modport sink   (input valid, input param_u, input point_0, input point_1,
                    input point_2, input point_3, output ready);
endinterface

interface bss_out_if import bss_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] curve_value;

    modport source (output valid, output curve_value, input ready);
    modport sink   (input valid, input curve_value, output ready);
endinterface

/* sv/bss_coef.sv */
// Polynomial coefficient stages: point combinations, tension products, sums.
// Depends on bss_pkg.
module bss_coef import bss_pkg::*;
(
    input  logic                         clk,
    input  bss_coef_ld_t                 ld,
    input  logic        [T_W-1:0]        tension,
    input  logic signed [POINT_BITS-1:0] point_0,
    input  logic signed [POINT_BITS-1:0] point_1,
    input  logic signed [POINT_BITS-1:0] point_2,
    input  logic signed [POINT_BITS-1:0] point_3,
    output bss_coef_t                    coef3,
    output bss_coef_t                    coef2,
    output bss_coef_t                    coef1,
    output bss_coef_t                    coef0
);

    logic signed [L_W-1:0] e0, e1, e2, e3, d21, d20;
    logic signed [L_W-1:0] lin3_next, lin2_next, lin1_next, lin0_next;
    logic signed [L_W-1:0] b3_next, b2_next, b0_next;
    logic signed [L_W-1:0] lin3_reg, lin2_reg, lin1_reg, lin0_reg;
    logic signed [L_W-1:0] b3_reg, b2_reg, b0_reg;
    logic signed [L_W-1:0] b3_d_reg, b2_d_reg, b0_d_reg;
    logic signed [PR_W-1:0] t_ext;
    logic signed [PR_W-1:0] prod3_next, prod2_next, prod1_next, prod0_next;
    logic signed [PR_W-1:0] prod3_reg, prod2_reg, prod1_reg, prod0_reg;
    bss_coef_t c3_next, c2_next, c1_next, c0_next;
    bss_coef_t c3_reg, c2_reg, c1_reg, c0_reg;

    always_comb
    begin
        e0  = L_W'(point_0);
        e1  = L_W'(point_1);
        e2  = L_W'(point_2);
        e3  = L_W'(point_3);
        d21 = e2 - e1;
        d20 = e2 - e0;
        lin3_next = e3 - e0 + (d21 <<< 3) + d21;
        lin2_next = (e0 <<< 1) + e0 + (e1 <<< 3) + (e1 <<< 2) - (e2 <<< 4) + e2;
        lin1_next = (d20 <<< 1) + d20;
        lin0_next = e0 - (e1 <<< 1) + e2;
        b3_next   = -((d21 <<< 3) + (d21 <<< 2));
        b2_next   = (d21 <<< 4) + (d21 <<< 1);
        b0_next   = (e1 <<< 2) + (e1 <<< 1);
    end

    always_comb
    begin
        t_ext      = $signed(PR_W'(tension));
        prod3_next = PR_W'(lin3_reg) * t_ext;
        prod2_next = PR_W'(lin2_reg) * t_ext;
        prod1_next = PR_W'(lin1_reg) * t_ext;
        prod0_next = PR_W'(lin0_reg) * t_ext;
    end

    always_comb
    begin
        c3_next = (C_W'(b3_d_reg) <<< IN_Q) + C_W'(prod3_reg);
        c2_next = (C_W'(b2_d_reg) <<< IN_Q) + C_W'(prod2_reg);
        c1_next = C_W'(prod1_reg);
        c0_next = (C_W'(b0_d_reg) <<< IN_Q) + C_W'(prod0_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ld.lin)
        begin
            lin3_reg <= lin3_next;
            lin2_reg <= lin2_next;
            lin1_reg <= lin1_next;
            lin0_reg <= lin0_next;
            b3_reg   <= b3_next;
            b2_reg   <= b2_next;
            b0_reg   <= b0_next;
        end
        if (ld.prod)
        begin
            prod3_reg <= prod3_next;
            prod2_reg <= prod2_next;
            prod1_reg <= prod1_next;
            prod0_reg <= prod0_next;
            b3_d_reg  <= b3_reg;
            b2_d_reg  <= b2_reg;
            b0_d_reg  <= b0_reg;
        end
        if (ld.coef)
        begin
            c3_reg <= c3_next;
            c2_reg <= c2_next;
            c1_reg <= c1_next;
            c0_reg <= c0_next;
        end
    end

    assign coef3 = c3_reg;
    assign coef2 = c2_reg;
    assign coef1 = c1_reg;
    assign coef0 = c0_reg;

endmodule

/* sv/bss_horner_step.sv */
// One Horner step, acc * u + addend modulo 2^A_W, over two register stages:
// chunked partial products, then their sum. Depends on bss_pkg.
module bss_horner_step import bss_pkg::*;
(
    input  logic             clk,
    input  bss_step_ld_t     ld,
    input  logic [A_W-1:0]   acc_in,
    input  logic [U_W-1:0]   u_in,
    input  logic [A_W-1:0]   add_in,
    output logic [A_W-1:0]   acc_out
);

    logic [PP_W-1:0] pp_next [N_CHUNK];
    logic [PP_W-1:0] pp_reg  [N_CHUNK];
    logic [A_W-1:0]  add_reg;
    logic [A_W-1:0]  acc_next;
    logic [A_W-1:0]  acc_reg;

    always_comb
    begin
        for (int j = 0; j < N_CHUNK; j++)
        begin
            pp_next[j] = PP_W'(acc_in[j * CH_W +: CH_W]) * PP_W'(u_in);
        end
    end

    always_comb
    begin
        acc_next = add_reg;
        for (int j = 0; j < N_CHUNK; j++)
        begin
            acc_next = acc_next + (A_W'(pp_reg[j]) << (j * CH_W));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.pp)
        begin
            for (int j = 0; j < N_CHUNK; j++)
            begin
                pp_reg[j] <= pp_next[j];
            end
            add_reg <= add_in;
        end
        if (ld.sum)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule

/* sv/beta_spline_segment_eval_core.sv */
// Top level of the cubic beta-spline segment evaluator (one channel).
// Depends on bss_pkg, bss_if, bss_coef and bss_horner_step.
//
//  port      | kind        | payload
//  ----------+-------------+--------------------------------------------
//  sample    | stream sink | param_u, point_0 .. point_3
//  result    | stream src  | curve_value
//  cfg_wr_*  | write only  | tension (17 bits, Q1.16)
//
// One item per cycle while the output is not stalled; the 12-stage pipeline is:
// coefficients, three two-stage Horner multiply-adds, range check and the
// two-stage multiply by the reciprocal of three.
// Each stage holds while its successor is full and stalled, so empty stages
// still take new items while the output waits. Reset clears the valid bits
// and sets tension to 1.0; there is no clearing pass.
module beta_spline_segment_eval_core import bss_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    bss_in_if.sink          sample,
    bss_out_if.source       result,
    input  logic            cfg_wr_en,
    input  logic [T_W-1:0]  cfg_wr_data
);

    logic [T_W-1:0]  tension_reg;
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] adv;
    logic [NSTG-1:0] vin;
    logic [NSTG-1:0] ld;

    logic [U_W-1:0] u_pipe_reg [7];
    bss_coef_t      c1_pipe_reg [2];
    bss_coef_t      c0_pipe_reg [4];
    bss_coef_t      coef3, coef2, coef1, coef0;

    logic [A_W-1:0] h1_acc_in, h1_add_in, h1_out;
    logic [A_W-1:0] h2_add_in, h2_out;
    logic [A_W-1:0] h3_add_in, h3_out;

    logic signed [S_W-1:0] s_val;
    logic signed [E_W-1:0] v_val;
    logic [W_W-1:0]        w_next, w_reg;
    logic                  sat_hi_next, sat_lo_next;
    logic                  sat_hi_reg, sat_lo_reg, sat_hi_d_reg, sat_lo_d_reg;

    logic [PLL_W-1:0] dll_reg;
    logic [PLH_W-1:0] dlh_reg;
    logic [PHL_W-1:0] dhl_reg;
    logic [PHH_W-1:0] dhh_reg;
    logic [P_W-1:0]   psum;
    logic [OUT_BITS-1:0] qw;
    logic signed [OUT_BITS-1:0] out_next, out_reg;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tension_reg <= TENSION_RST;
        end
        else if (cfg_wr_en)
        begin
            tension_reg <= cfg_wr_data;
        end
    end

    // advance a stage when it is empty or its successor advances
    always_comb
    begin
        adv[NSTG-1] = !valid_reg[NSTG-1] || result.ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign vin = {valid_reg[NSTG-2:0], sample.valid};
    assign ld  = adv & vin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= vin[i];
                end
            end
        end
    end

    assign sample.ready = adv[0];

    bss_coef u_coef
    (
        .clk     (clk),
        .ld      ('{lin: ld[0], prod: ld[1], coef: ld[2]}),
        .tension (tension_reg),
        .point_0 (sample.point_0),
        .point_1 (sample.point_1),
        .point_2 (sample.point_2),
        .point_3 (sample.point_3),
        .coef3   (coef3),
        .coef2   (coef2),
        .coef1   (coef1),
        .coef0   (coef0)
    );

    // carry u and the late coefficients alongside
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            u_pipe_reg[0] <= sample.param_u;
        end
        for (int i = 1; i < 7; i++)
        begin
            if (ld[i])
            begin
                u_pipe_reg[i] <= u_pipe_reg[i-1];
            end
        end
        if (ld[3])
        begin
            c1_pipe_reg[0] <= coef1;
            c0_pipe_reg[0] <= coef0;
        end
        if (ld[4])
        begin
            c1_pipe_reg[1] <= c1_pipe_reg[0];
            c0_pipe_reg[1] <= c0_pipe_reg[0];
        end
        if (ld[5])
        begin
            c0_pipe_reg[2] <= c0_pipe_reg[1];
        end
        if (ld[6])
        begin
            c0_pipe_reg[3] <= c0_pipe_reg[2];
        end
    end

    assign h1_acc_in = A_W'(coef3);
    assign h1_add_in = A_W'(coef2) << IN_Q;
    assign h2_add_in = A_W'(c1_pipe_reg[1]) << (2 * IN_Q);
    assign h3_add_in = A_W'(c0_pipe_reg[3]) << (3 * IN_Q);

    bss_horner_step u_step1
    (
        .clk     (clk),
        .ld      ('{pp: ld[3], sum: ld[4]}),
        .acc_in  (h1_acc_in),
        .u_in    (u_pipe_reg[2]),
        .add_in  (h1_add_in),
        .acc_out (h1_out)
    );

    bss_horner_step u_step2
    (
        .clk     (clk),
        .ld      ('{pp: ld[5], sum: ld[6]}),
        .acc_in  (h1_out),
        .u_in    (u_pipe_reg[4]),
        .add_in  (h2_add_in),
        .acc_out (h2_out)
    );

    bss_horner_step u_step3
    (
        .clk     (clk),
        .ld      ('{pp: ld[7], sum: ld[8]}),
        .acc_in  (h2_out),
        .u_in    (u_pipe_reg[6]),
        .add_in  (h3_add_in),
        .acc_out (h3_out)
    );

    // floor to output fraction, offset to nonnegative, halve
    always_comb
    begin
        s_val       = $signed(h3_out[A_W-1:SH]);
        v_val       = E_W'(s_val) + OFF_V;
        sat_lo_next = v_val[E_W-1];
        sat_hi_next = (v_val >= LIM_V);
        w_next      = v_val[W_W:1];
    end

    always_ff @(posedge clk)
    begin
        if (ld[9])
        begin
            w_reg      <= w_next;
            sat_hi_reg <= sat_hi_next;
            sat_lo_reg <= sat_lo_next;
        end
        if (ld[10])
        begin
            dll_reg      <= PLL_W'(w_reg[W_LO-1:0]) * PLL_W'(DIV3_M[M_LO-1:0]);
            dlh_reg      <= PLH_W'(w_reg[W_LO-1:0]) * PLH_W'(DIV3_M[M_W-1:M_LO]);
            dhl_reg      <= PHL_W'(w_reg[W_W-1:W_LO]) * PHL_W'(DIV3_M[M_LO-1:0]);
            dhh_reg      <= PHH_W'(w_reg[W_W-1:W_LO]) * PHH_W'(DIV3_M[M_W-1:M_LO]);
            sat_hi_d_reg <= sat_hi_reg;
            sat_lo_d_reg <= sat_lo_reg;
        end
        if (ld[11])
        begin
            out_reg <= out_next;
        end
    end

    // quotient by three, remove offset, saturate
    always_comb
    begin
        psum = P_W'(dll_reg)
             + (P_W'(dlh_reg) << M_LO)
             + (P_W'(dhl_reg) << W_LO)
             + (P_W'(dhh_reg) << (W_LO + M_LO));
        qw   = psum[DIV_K +: OUT_BITS];
        priority if (sat_hi_d_reg)
        begin
            out_next = OUT_MAX;
        end
        else if (sat_lo_d_reg)
        begin
            out_next = OUT_MIN;
        end
        else
        begin
            out_next = $signed({~qw[OUT_BITS-1], qw[OUT_BITS-2:0]});
        end
    end

    assign result.valid       = valid_reg[NSTG-1];
    assign result.curve_value = out_reg;

endmodule

/* bench/beta_spline_segment_eval_core_test.sv */
// Self-checking bench for beta_spline_segment_eval_core: streams samples, predicts each
// curve value from the tension in force, and compares every result transfer in order.
// Depends on bss_pkg, bss_in_if / bss_out_if and beta_spline_segment_eval_core.
module beta_spline_segment_eval_core_test;
    import bss_pkg::*;

    localparam int LATENCY     = NSTG;
    localparam int CYCLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [U_W-1:0] U_ONE = U_W'(1 << IN_Q);
    localparam logic [U_W-1:0] U_TOP = {U_W{1'b1}};
    localparam logic [T_W-1:0] T_TOP = {T_W{1'b1}};
    localparam logic signed [POINT_BITS-1:0] PT_MAX = {1'b0, {(POINT_BITS - 1){1'b1}}};
    localparam logic signed [POINT_BITS-1:0] PT_MIN = {1'b1, {(POINT_BITS - 1){1'b0}}};

    logic            clk;
    logic            rst_n;
    logic            cfg_wr_en;
    logic [T_W-1:0]  cfg_wr_data;

    bss_in_if  sample_if();
    bss_out_if result_if();

    beta_spline_segment_eval_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample_if),
        .result      (result_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    logic [T_W-1:0]             tension_now;
    logic signed [OUT_BITS-1:0] curve_due[$];
    int                         mismatch_count = 0;
    int                         send_idle_pct  = 0;
    int                         recv_stall_pct = 0;
    int                         hold_left      = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic signed [OUT_BITS-1:0] curve_at(
        input logic [U_W-1:0]               u,
        input logic signed [POINT_BITS-1:0] a,
        input logic signed [POINT_BITS-1:0] b,
        input logic signed [POINT_BITS-1:0] c,
        input logic signed [POINT_BITS-1:0] d,
        input logic [T_W-1:0]               tension
    );
        logic signed [127:0] p0, p1, p2, p3, t, uu, k3, k2, k1, k0, acc, q;
        p0 = a;
        p1 = b;
        p2 = c;
        p3 = d;
        t  = tension;
        uu = u;
        k3 = 12 * (p1 - p2) * 65536 + (-p0 - 9 * p1 + 9 * p2 + p3) * t;
        k2 = 18 * (p2 - p1) * 65536 + (3 * p0 + 12 * p1 - 15 * p2) * t;
        k1 = 3 * (p2 - p0) * t;
        k0 = 6 * p1 * 65536 + (p0 - 2 * p1 + p2) * t;
        acc = k3;
        acc = acc * uu + (k2 <<< IN_Q);
        acc = acc * uu + (k1 <<< (2 * IN_Q));
        acc = acc * uu + (k0 <<< (3 * IN_Q));
        acc = acc >>> (4 * IN_Q - FRAC_BITS);
        q = acc / 6;
        if (acc < 0 && q * 6 != acc)
            q = q - 1;
        if (q > OUT_MAX)
            q = OUT_MAX;
        if (q < OUT_MIN)
            q = OUT_MIN;
        return q[OUT_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_sample(
        input logic [U_W-1:0]               u,
        input logic signed [POINT_BITS-1:0] a,
        input logic signed [POINT_BITS-1:0] b,
        input logic signed [POINT_BITS-1:0] c,
        input logic signed [POINT_BITS-1:0] d
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_if.valid <= 1'b0;
            @(posedge clk);
        end
        sample_if.valid   <= 1'b1;
        sample_if.param_u <= u;
        sample_if.point_0 <= a;
        sample_if.point_1 <= b;
        sample_if.point_2 <= c;
        sample_if.point_3 <= d;
        do
            @(posedge clk);
        while (!sample_if.ready);
        curve_due.push_back(curve_at(u, a, b, c, d, tension_now));
    endtask

    function automatic logic signed [POINT_BITS-1:0] random_point();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? PT_MAX : PT_MIN;
            1: return POINT_BITS'(int'($urandom_range(2000)) - 1000);
            default: return POINT_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [U_W-1:0] random_u();
        case ($urandom_range(9))
            0: return U_W'($urandom_range(int'(U_TOP), int'(U_ONE) + 1));
            1: return $urandom_range(1) ? U_ONE : '0;
            default: return U_W'($urandom_range(int'(U_ONE)));
        endcase
    endfunction

    task automatic send_random_sample();
        send_sample(random_u(), random_point(), random_point(), random_point(),
                    random_point());
    endtask

    task automatic wait_drain();
        sample_if.valid <= 1'b0;
        while (curve_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic set_tension(input logic [T_W-1:0] value);
        wait_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tension_now = value;
    endtask

    task automatic test_reset_tension();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_sample('0, 24'sd1, 24'sd2, 24'sd3, 24'sd4);
        send_sample(U_ONE, 24'sd1, 24'sd2, 24'sd3, 24'sd4);
        send_sample(U_ONE >> 1, PT_MAX, PT_MAX, PT_MAX, PT_MAX);
        send_sample(U_ONE >> 1, PT_MIN, PT_MIN, PT_MIN, PT_MIN);
        send_sample(U_TOP, PT_MAX, PT_MIN, PT_MAX, PT_MIN);
        send_sample(U_TOP, PT_MIN, PT_MAX, PT_MIN, PT_MAX);
        send_sample(U_TOP, PT_MIN, PT_MIN, PT_MAX, PT_MAX);
        send_sample(U_W'(1), '0, '0, '0, '0);
        send_sample(U_ONE - 1, PT_MIN, PT_MAX, PT_MAX, PT_MIN);
        send_sample('0, PT_MAX, PT_MIN, PT_MIN, PT_MAX);
    endtask

    task automatic test_tension_extremes();
        set_tension('0);
        send_sample(U_ONE >> 2, PT_MAX, PT_MIN, PT_MAX, PT_MIN);
        send_sample(U_TOP, PT_MIN, PT_MAX, PT_MIN, PT_MAX);
        send_sample('0, 24'sd100, -24'sd200, 24'sd300, -24'sd400);
        set_tension(T_TOP);
        send_sample(U_TOP, PT_MAX, PT_MIN, PT_MAX, PT_MIN);
        send_sample(U_TOP, PT_MIN, PT_MAX, PT_MIN, PT_MAX);
        send_sample(U_ONE, PT_MAX, PT_MAX, PT_MIN, PT_MIN);
        send_sample('0, PT_MIN, PT_MIN, PT_MAX, PT_MAX);
        set_tension(T_W'(1));
        send_sample(U_ONE >> 1, PT_MAX, PT_MIN, PT_MAX, PT_MIN);
        send_sample(U_TOP, PT_MIN, PT_MAX, PT_MAX, PT_MIN);
        send_sample(U_ONE, -24'sd1, 24'sd1, -24'sd1, 24'sd1);
        send_sample('0, 24'sd7, -24'sd7, 24'sd7, -24'sd7);
    endtask

    task automatic test_backpressure();
        set_tension(TENSION_RST >> 1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // hold the output so the pipeline fills and stalls the input
        hold_left = HOLD_CYCLES;
        repeat (60) send_random_sample();
        wait_drain();
        repeat (10) send_random_sample();
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random_sample();
    endtask

    task automatic test_random_stream();
        set_tension(TENSION_RST);
        run_phase(0, 0, 95);
        set_tension(T_W'($urandom_range(int'(TENSION_RST), 1)));
        run_phase(74, 0, 95);
        set_tension(T_W'($urandom()));
        run_phase(0, 74, 95);
        set_tension(T_W'($urandom_range(int'(TENSION_RST), 1)));
        run_phase(14, 14, 95);
    endtask

    initial
    begin : result_sink
        logic signed [OUT_BITS-1:0] want;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready)
            begin
                if (curve_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected curve_value %0d",
                                              result_if.curve_value));
                end
                else
                begin
                    want = curve_due.pop_front();
                    if (result_if.curve_value !== want)
                        report_mismatch($sformatf("curve_value got %0d want %0d",
                                                  result_if.curve_value, want));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < CYCLE_LIMIT)
        begin
            @(posedge clk);
            if ((sample_if.valid && sample_if.ready) ||
                (result_if.valid && result_if.ready) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        tension_now         = TENSION_RST;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        sample_if.valid    <= 1'b0;
        sample_if.param_u  <= '0;
        sample_if.point_0  <= '0;
        sample_if.point_1  <= '0;
        sample_if.point_2  <= '0;
        sample_if.point_3  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_tension();
        test_tension_extremes();
        test_backpressure();
        test_random_stream();
        wait_drain();

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/bss_pkg.sv
sv/bss_if.sv
sv/bss_coef.sv
sv/bss_horner_step.sv
sv/beta_spline_segment_eval_core.sv
bench/beta_spline_segment_eval_core_test.sv
